### hdl/isc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the integer literal scanner
// no dependencies

package isc_pkg;

   localparam int unsigned CharWidth   = 8;
   localparam int unsigned ValueWidth  = 32;
   localparam int unsigned StatusWidth = 3;

   localparam logic [ValueWidth-1:0] NegLimit = 32'h8000_0000;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK       = 3'd0,
      ST_NAN      = 3'd1,
      ST_SIGN     = 3'd2,
      ST_LEADZERO = 3'd3,
      ST_DECOVF   = 3'd4,
      ST_HEXLONG  = 3'd5,
      ST_HEXEMPTY = 3'd6,
      ST_NEGRANGE = 3'd7
   } status_type;

   // classification of one input byte, flags already gated by end of input
   typedef struct packed {
      logic       is_dig;
      logic       is_zero;
      logic       is_hex;
      logic       is_minus;
      logic       is_x;
      logic [3:0] nibble;
   } char_class_type;

   typedef struct packed {
      logic [ValueWidth-1:0] value;
      status_type            status;
   } result_type;

endpackage

### hdl/isc_req_if.sv
`timescale 1ns / 1ps
// input channel: one character beat with end of input flag
// depends on isc_pkg

interface isc_req_if;
   logic                            valid;
   logic                            ready;
   logic [isc_pkg::CharWidth-1:0]   character;
   logic                            end_of_input;

   modport source (output valid, output character, output end_of_input, input ready);
   modport sink   (input valid, input character, input end_of_input, output ready);
endinterface

### hdl/isc_rsp_if.sv
`timescale 1ns / 1ps
// result channel: parsed value and status
// depends on isc_pkg

interface isc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [isc_pkg::ValueWidth-1:0]   value;
   logic [isc_pkg::StatusWidth-1:0]  status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

### hdl/isc_char_class.sv
`timescale 1ns / 1ps
// byte classifier: digit, hex digit, minus, x/X, nibble value
// depends on isc_pkg

module isc_char_class (
   input  logic [isc_pkg::CharWidth-1:0] character,
   input  logic                          end_of_input,
   output isc_pkg::char_class_type       cls
);

   logic dec_c;
   logic low_c;
   logic upp_c;

   always_comb begin
      dec_c = (character >= 8'h30) && (character <= 8'h39);
      low_c = (character >= 8'h61) && (character <= 8'h66);
      upp_c = (character >= 8'h41) && (character <= 8'h46);

      cls.is_dig   = !end_of_input && dec_c;
      cls.is_zero  = !end_of_input && (character == 8'h30);
      cls.is_hex   = !end_of_input && (dec_c || low_c || upp_c);
      cls.is_minus = !end_of_input && (character == 8'h2d);
      cls.is_x     = !end_of_input && ((character == 8'h78) || (character == 8'h58));

      // letters a-f and A-F differ only in bit 5, low nibble 1..6 maps to 10..15
      if (dec_c) begin
         cls.nibble = character[3:0];
      end else begin
         cls.nibble = 4'(character[3:0] + 4'd9);
      end
   end

endmodule

### hdl/isc_core.sv
`timescale 1ns / 1ps
// scanner state machine: phase, sign, accumulator, hex digit count
// depends on isc_pkg

module isc_core #(
   parameter int unsigned MAX_HEX_DIGITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  isc_pkg::char_class_type cls,
   output logic                    emit,
   output isc_pkg::result_type     result
);

   localparam int unsigned CntWidth = $clog2(MAX_HEX_DIGITS + 1);

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_MINUS    = 3'd1,
      PH_ZERO     = 3'd2,
      PH_DEC      = 3'd3,
      PH_HEXSTART = 3'd4,
      PH_HEX      = 3'd5
   } phase_type;

   phase_type                          phase_ff, phase_in;
   logic                               neg_ff, neg_in;
   logic [isc_pkg::ValueWidth-1:0]     acc_ff, acc_in;
   logic [CntWidth-1:0]                cnt_ff, cnt_in;

   logic [isc_pkg::ValueWidth+3:0]     dec_sum;
   logic                               dec_ovf;
   logic [isc_pkg::ValueWidth-1:0]     fin_value;
   isc_pkg::status_type                fin_status;

   // acc * 10 + digit as (acc << 3) + (acc << 1) + digit
   always_comb begin
      dec_sum = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
              + {32'd0, cls.nibble};
      dec_ovf = (dec_sum[isc_pkg::ValueWidth+3:isc_pkg::ValueWidth] != 4'd0);
   end

   // terminator after a complete literal
   always_comb begin
      fin_value  = acc_ff;
      fin_status = isc_pkg::ST_OK;
      if (neg_ff) begin
         if (acc_ff > isc_pkg::NegLimit) begin
            fin_value  = '0;
            fin_status = isc_pkg::ST_NEGRANGE;
         end else begin
            fin_value = 32'd0 - acc_ff;
         end
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      neg_in        = neg_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      emit          = 1'b0;
      result.value  = '0;
      result.status = isc_pkg::ST_OK;

      unique case (phase_ff)
         PH_IDLE, PH_MINUS: begin
            if (cls.is_dig) begin
               if (cls.is_zero) begin
                  phase_in = PH_ZERO;
               end else begin
                  acc_in   = {28'd0, cls.nibble};
                  phase_in = PH_DEC;
               end
            end else if (cls.is_minus && phase_ff == PH_IDLE) begin
               neg_in   = 1'b1;
               phase_in = PH_MINUS;
            end else begin
               emit          = 1'b1;
               result.status = (phase_ff == PH_IDLE) ? isc_pkg::ST_NAN : isc_pkg::ST_SIGN;
            end
         end
         PH_ZERO: begin
            if (cls.is_x) begin
               cnt_in   = '0;
               acc_in   = '0;
               phase_in = PH_HEXSTART;
            end else if (cls.is_hex) begin
               emit          = 1'b1;
               result.status = isc_pkg::ST_LEADZERO;
            end else begin
               emit = 1'b1;
            end
         end
         PH_DEC: begin
            if (cls.is_dig) begin
               if (dec_ovf) begin
                  emit          = 1'b1;
                  result.status = isc_pkg::ST_DECOVF;
               end else begin
                  acc_in = dec_sum[isc_pkg::ValueWidth-1:0];
               end
            end else begin
               emit          = 1'b1;
               result.value  = fin_value;
               result.status = fin_status;
            end
         end
         PH_HEXSTART, PH_HEX: begin
            if (cls.is_hex) begin
               if (cnt_ff == CntWidth'(MAX_HEX_DIGITS)) begin
                  emit          = 1'b1;
                  result.status = isc_pkg::ST_HEXLONG;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  acc_in   = {acc_ff[isc_pkg::ValueWidth-5:0], cls.nibble};
                  phase_in = PH_HEX;
               end
            end else if (cnt_ff == '0) begin
               emit          = 1'b1;
               result.status = isc_pkg::ST_HEXEMPTY;
            end else begin
               emit          = 1'b1;
               result.value  = fin_value;
               result.status = fin_status;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // every result returns the scanner to idle with state cleared
      if (emit || phase_in == PH_IDLE) begin
         phase_in = PH_IDLE;
         neg_in   = 1'b0;
         acc_in   = '0;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         cnt_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_idle_after_result : assert property (@(posedge clock) disable iff (reset)
      step && emit |=> phase_ff == PH_IDLE && acc_ff == '0 && !neg_ff)
      else $error("scanner not idle after a result");

   a_hex_count_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntWidth'(MAX_HEX_DIGITS))
      else $error("hex digit count past limit");

   a_dec_nonzero : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DEC |-> acc_ff != '0)
      else $error("decimal phase with zero accumulator");

   a_count_only_hex : assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_HEX |-> cnt_ff == '0)
      else $error("hex digit count outside hex phase");

endmodule

### hdl/integer_literal_scanner.sv
`timescale 1ns / 1ps
// Integer literal scanner, one character beat per cycle.
// The terminating character is held in the input register and its result beat
// is then captured in the result register.
// Throughput: one character per cycle; a waiting result stalls the scanner
// and the input register holds one more beat. Synchronous reset returns to idle.
// depends on isc_pkg, isc_req_if, isc_rsp_if, isc_char_class, isc_core

module integer_literal_scanner #(
   parameter int unsigned MAX_HEX_DIGITS = 8
) (
   input  logic      clock,
   input  logic      reset,
   isc_req_if.sink   req_bus,
   isc_rsp_if.source rsp_bus
);

   logic                                in_valid_ff, in_valid_in;
   logic [isc_pkg::CharWidth-1:0]       in_char_ff, in_char_in;
   logic                                in_eoi_ff, in_eoi_in;

   logic                                out_valid_ff, out_valid_in;
   isc_pkg::result_type                 out_res_ff, out_res_in;

   logic                                advance;
   logic                                emit;
   isc_pkg::char_class_type             cls;
   isc_pkg::result_type                 result;

   isc_char_class u_class (
      .character    (in_char_ff),
      .end_of_input (in_eoi_ff),
      .cls          (cls)
   );

   isc_core #(
      .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cls    (cls),
      .emit   (emit),
      .result (result)
   );

   // the held beat moves on when the result register is free or draining
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_eoi_in   = in_eoi_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
         in_char_in  = req_bus.character;
         in_eoi_in   = req_bus.end_of_input;
      end

      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (advance && emit) begin
         out_valid_in = 1'b1;
         out_res_in   = result;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_char_ff <= in_char_in;
      in_eoi_ff  <= in_eoi_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_bus.valid  = out_valid_ff;
   assign rsp_bus.value  = out_res_ff.value;
   assign rsp_bus.status = out_res_ff.status;

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_bus.ready |-> !advance)
      else $error("pending result overwritten");

   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.status != isc_pkg::ST_OK |-> out_res_ff.value == '0)
      else $error("error result with nonzero value");

   a_held_beat_waits : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_char_ff))
      else $error("held character lost");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// self-checking bench for integer_literal_scanner: directed and random literal streams with a scoreboard
// depends on isc_pkg, isc_req_if, isc_rsp_if and the scanner rtl

module tb;

   localparam int CharWidth     = isc_pkg::CharWidth;
   localparam int ValueWidth    = isc_pkg::ValueWidth;
   localparam int HexDigitLimit = 8;
   localparam int CycleLimit    = 200000;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_SIGN,
      SCAN_ZERO,
      SCAN_DEC,
      SCAN_HEX_OPEN,
      SCAN_HEX
   } scan_phase_type;

   typedef struct packed {
      logic [CharWidth-1:0] ch;
      logic                 eoi;
   } char_beat_type;

   logic clock = 1'b0;
   logic reset;

   isc_req_if req_bus ();
   isc_rsp_if rsp_bus ();

   integer_literal_scanner #(
      .MAX_HEX_DIGITS(HexDigitLimit)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   char_beat_type       char_queue[$];
   isc_pkg::result_type parsed_literals[$];
   isc_pkg::result_type literal_due;

   // scanner state mirrored by the predictor
   scan_phase_type        scan_phase = SCAN_IDLE;
   logic                  scan_negative = 1'b0;
   logic [ValueWidth-1:0] scan_magnitude = '0;
   int unsigned           scan_hex_count = 0;

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int hold_off_left  = 0;
   int chars_queued   = 0;
   int error_count    = 0;
   int cycle_count    = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------- literal predictor ----------------

   function automatic void emit_literal(logic [ValueWidth-1:0] value,
                                        isc_pkg::status_type status);
      isc_pkg::result_type r;
      r.value  = value;
      r.status = status;
      parsed_literals.push_back(r);
      scan_phase     = SCAN_IDLE;
      scan_negative  = 1'b0;
      scan_magnitude = '0;
      scan_hex_count = 0;
   endfunction

   function automatic void close_literal();
      if (scan_negative) begin
         if (scan_magnitude > isc_pkg::NegLimit) emit_literal('0, isc_pkg::ST_NEGRANGE);
         else emit_literal(-scan_magnitude, isc_pkg::ST_OK);
      end else begin
         emit_literal(scan_magnitude, isc_pkg::ST_OK);
      end
   endfunction

   function automatic void scan_char(logic [CharWidth-1:0] ch, logic eoi);
      logic        is_dig;
      logic        is_hex;
      logic [3:0]  nibble;
      logic [35:0] widened;
      is_dig = !eoi && ch >= "0" && ch <= "9";
      is_hex = 1'b1;
      nibble = '0;
      if (eoi) is_hex = 1'b0;
      else if (ch >= "0" && ch <= "9") nibble = 4'(ch - "0");
      else if (ch >= "a" && ch <= "f") nibble = 4'(ch - "a" + 10);
      else if (ch >= "A" && ch <= "F") nibble = 4'(ch - "A" + 10);
      else is_hex = 1'b0;
      case (scan_phase)
         SCAN_IDLE, SCAN_SIGN: begin
            if (is_dig) begin
               scan_magnitude = ValueWidth'(nibble);
               scan_phase = (nibble == 0) ? SCAN_ZERO : SCAN_DEC;
            end else if (scan_phase == SCAN_IDLE && !eoi && ch == "-") begin
               scan_negative = 1'b1;
               scan_phase = SCAN_SIGN;
            end else begin
               emit_literal('0, (scan_phase == SCAN_IDLE) ? isc_pkg::ST_NAN
                                                          : isc_pkg::ST_SIGN);
            end
         end
         SCAN_ZERO: begin
            if (!eoi && (ch == "x" || ch == "X")) begin
               scan_magnitude = '0;
               scan_hex_count = 0;
               scan_phase = SCAN_HEX_OPEN;
            end else if (is_hex) begin
               emit_literal('0, isc_pkg::ST_LEADZERO);
            end else begin
               emit_literal('0, isc_pkg::ST_OK);
            end
         end
         SCAN_DEC: begin
            if (is_dig) begin
               widened = 36'(scan_magnitude) * 36'd10 + 36'(nibble);
               if (widened > 36'hFFFF_FFFF) emit_literal('0, isc_pkg::ST_DECOVF);
               else scan_magnitude = widened[ValueWidth-1:0];
            end else begin
               close_literal();
            end
         end
         default: begin
            if (is_hex) begin
               if (scan_hex_count + 1 > HexDigitLimit) begin
                  emit_literal('0, isc_pkg::ST_HEXLONG);
               end else begin
                  scan_hex_count++;
                  scan_magnitude = {scan_magnitude[ValueWidth-5:0], nibble};
                  scan_phase = SCAN_HEX;
               end
            end else if (scan_hex_count == 0) begin
               emit_literal('0, isc_pkg::ST_HEXEMPTY);
            end else begin
               close_literal();
            end
         end
      endcase
   endfunction

   // ---------------- stimulus helpers ----------------

   task automatic push_char(logic [CharWidth-1:0] ch, logic eoi);
      char_beat_type b;
      b.ch  = ch;
      b.eoi = eoi;
      char_queue.push_back(b);
      chars_queued++;
   endtask

   function automatic logic [CharWidth-1:0] random_digit(bit nonzero);
      return 8'("0" + $urandom_range(nonzero ? 1 : 0, 9));
   endfunction

   function automatic logic [CharWidth-1:0] random_hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'("0" + v);
      if ($urandom_range(0, 1) != 0) return 8'("a" + v - 10);
      return 8'("A" + v - 10);
   endfunction

   // a byte that cannot continue any literal
   function automatic logic [CharWidth-1:0] random_stop_char();
      logic [CharWidth-1:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                 (c >= "A" && c <= "F") || c == "x" || c == "X");
      return c;
   endfunction

   task automatic push_terminator();
      if ($urandom_range(0, 4) == 0) push_char(8'($urandom_range(0, 255)), 1'b1);
      else push_char(random_stop_char(), 1'b0);
   endtask

   task automatic push_literal();
      int     kind;
      int     ndig;
      int     pick;
      longint magnitude;
      string  text;
      kind = $urandom_range(0, 99);
      if (kind < 93 && $urandom_range(0, 2) == 0) push_char("-", 1'b0);
      if (kind < 30) begin
         ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 11) : $urandom_range(1, 4);
         push_char(random_digit(1), 1'b0);
         repeat (ndig - 1) push_char(random_digit(0), 1'b0);
         push_terminator();
      end else if (kind < 45) begin
         // values around the unsigned and negative limits
         case ($urandom_range(0, 2))
            0:       magnitude = 64'd4294967296;
            1:       magnitude = 64'd2147483648;
            default: magnitude = 64'd2147483649;
         endcase
         magnitude = magnitude + longint'($urandom_range(0, 2)) - 1;
         text = $sformatf("%0d", magnitude);
         for (int i = 0; i < text.len(); i++) push_char(text[i], 1'b0);
         push_terminator();
      end else if (kind < 75) begin
         push_char("0", 1'b0);
         push_char(($urandom_range(0, 1) != 0) ? "x" : "X", 1'b0);
         pick = $urandom_range(0, 11);
         if (pick == 0) ndig = 0;
         else if (pick == 1) ndig = $urandom_range(9, 10);
         else if (pick < 5) ndig = HexDigitLimit;
         else ndig = $urandom_range(1, HexDigitLimit);
         repeat (ndig) push_char(random_hex_char(), 1'b0);
         push_terminator();
      end else if (kind < 83) begin
         push_char("0", 1'b0);
         push_terminator();
      end else if (kind < 88) begin
         push_char("0", 1'b0);
         push_char(random_hex_char(), 1'b0);
      end else if (kind < 93) begin
         push_char("-", 1'b0);
         push_terminator();
      end else begin
         push_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
   endtask

   task automatic queue_random_chars(int count);
      int target;
      target = chars_queued + count;
      while (chars_queued < target) push_literal();
   endtask

   task automatic wait_drained();
      while (char_queue.size() != 0 || parsed_literals.size() != 0 || req_bus.valid)
         @(negedge clock);
   endtask

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) scan_char(req_bus.character, req_bus.end_of_input);
         if (!req_bus.valid || req_bus.ready) begin
            if (char_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_bus.valid        <= 1'b1;
               req_bus.character    <= char_queue[0].ch;
               req_bus.end_of_input <= char_queue[0].eoi;
               char_queue.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (parsed_literals.size() == 0) begin
               $display("%0t: unexpected result, value %h status %0d",
                        $time, rsp_bus.value, rsp_bus.status);
               error_count++;
            end else begin
               literal_due = parsed_literals.pop_front();
               if (rsp_bus.value !== literal_due.value) begin
                  $display("%0t: value mismatch, expected %h, got %h",
                           $time, literal_due.value, rsp_bus.value);
                  error_count++;
               end
               if (rsp_bus.status !== literal_due.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, literal_due.status, rsp_bus.status);
                  error_count++;
               end
            end
         end
         // long hold-off lets the scanner back up into its input
         if (hold_off_left > 0) begin
            hold_off_left = hold_off_left - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------- test sequence ----------------

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.character    = '0;
      req_bus.end_of_input = 1'b0;
      rsp_bus.ready        = 1'b0;
      send_idle_pct        = 33;
      recv_idle_pct        = 58;

      // directed: bad starts, sign errors, zero cases, short hex and negatives
      push_char(8'h00, 1'b1);
      push_char(8'h00, 1'b0);
      push_char(8'hFF, 1'b0);
      push_char("-", 1'b0); push_char(" ", 1'b0);
      push_char("0", 1'b0); push_char("a", 1'b0);
      push_char("0", 1'b0); push_char(8'h00, 1'b1);
      push_char("-", 1'b0); push_char("0", 1'b0); push_char(";", 1'b0);
      push_char("0", 1'b0); push_char("x", 1'b0); push_char(8'h5A, 1'b1);
      push_char("0", 1'b0); push_char("X", 1'b0); push_char("F", 1'b0); push_char(",", 1'b0);
      push_char("-", 1'b0); push_char("9", 1'b0); push_char(8'hFF, 1'b1);
      push_char("7", 1'b0); push_char(")", 1'b0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      queue_random_chars(230);
      wait_drained();

      send_idle_pct = 0;
      hold_off_left = 300;
      queue_random_chars(60);
      wait_drained();

      send_idle_pct = 58;
      recv_idle_pct = 33;
      queue_random_chars(230);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_chars(230);
      push_char(8'h00, 1'b1);
      wait_drained();

      repeat (10) @(negedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
